>>> hw/rtl/sdq_pkg.sv
`default_nettype none

package sdq_pkg;

  // Default sizes handed to the top level.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  // Fixed field widths of the request and result streams.
  localparam int ID_BITS     = 8;
  localparam int STATUS_BITS = 2;
  localparam int IN_TIME_BITS = 32;

  // Request kinds.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WOKEN  = 1'b1;

  // Add status codes.
  localparam logic [STATUS_BITS-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DEC    = 2'd2,
    OP_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ID_BITS-1:0] new_id;
  } sdq_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sdq_cell.sv
`default_nettype none

module sdq_cell
  import sdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int INDEX       = 0
) (
  input  wire logic                           clk,
  input  wire sdq_ctrl_t                      ctrl,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] pos,
  input  wire logic [TIME_BITS-1:0]           rem,
  input  wire logic [TIME_BITS-1:0]           left_delta,
  input  wire logic [ID_BITS-1:0]             left_id,
  input  wire logic [TIME_BITS-1:0]           right_delta,
  input  wire logic [ID_BITS-1:0]             right_id,
  output logic      [TIME_BITS-1:0]           delta,
  output logic      [ID_BITS-1:0]             id
);

  localparam int IW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic tok;
  logic tok_left;
  logic behind;

  // The insertion point is the cell whose index equals pos; cells behind it
  // take their left neighbour's entry.
  assign tok    = (pos == IDX);
  assign behind = (IDX > pos);

  generate
    if (INDEX > 0) begin : g_left
      assign tok_left = (pos == IW'(INDEX - 1));
    end else begin : g_first
      assign tok_left = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (tok) begin
          delta <= rem;
          id    <= ctrl.new_id;
        end else if (behind) begin
          // The entry displaced from the insertion point loses the new delay.
          delta <= tok_left ? (left_delta - rem) : left_delta;
          id    <= left_id;
        end
      end
      OP_DEC: begin
        if (INDEX == 0 && delta != '0) begin
          delta <= delta - TIME_BITS'(1);
        end
      end
      OP_POP: begin
        delta <= right_delta;
        id    <= right_id;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/sleep_delta_queue_top.sv
// One request at a time, paced by the insert token walking one cell a cycle: an add walks
// from the head until it finds its place, then inserts and answers; an ignored or refused
// add answers without walking; a tick decrements the head entry, then reports each due
// entry in turn. The next request is taken only once the last is done, and a stall on the
// result side holds the block. Reset (rst, synchronous, active high) empties the queue.
`default_nettype none

module sleep_delta_queue_top
  import sdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // thread_id [7:0], sleep_time [39:8]
  input  wire logic        s_axis_tuser,  // cmd
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // woken_id [7:0], status [9:8], zero [15:10]
  output logic             m_axis_tuser,  // result_kind
  output logic             m_axis_tlast   // last
);

  localparam int IW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_IDX = IW'(QUEUE_DEPTH);
  localparam int NEXT_IDX = (QUEUE_DEPTH > 1) ? 1 : 0;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_WALK = 5'b00100,
    S_TICK = 5'b01000,
    S_REL  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // The chain of cells holds the entries in wake order, slot 0 at the head.
  // Only slots below occ hold live entries; the rest never decide any result.
  logic [TIME_BITS-1:0] delta_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   id_q    [QUEUE_DEPTH];

  logic [IW-1:0]        occ;
  logic [IW-1:0]        pos;
  logic [TIME_BITS-1:0] rem;
  logic [ID_BITS-1:0]   new_id;
  sdq_ctrl_t            ctrl;

  // Output register: one finished result waits here until it is taken.
  logic                   out_valid;
  logic                   out_kind;
  logic [ID_BITS-1:0]     out_id;
  logic [STATUS_BITS-1:0] out_status;
  logic                   out_last;

  logic                   emit;
  logic                   emit_kind;
  logic [ID_BITS-1:0]     emit_id;
  logic [STATUS_BITS-1:0] emit_status;
  logic                   emit_last;
  logic                   can_emit;

  logic [TIME_BITS-1:0] t_sat;
  logic [TIME_BITS-1:0] sel_delta;
  logic                 at_end;
  logic                 hit;
  logic                 head_zero;
  logic                 next_zero;
  logic                 accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign can_emit      = !out_valid || m_axis_tready;

  // A sleep time beyond the delta width saturates to the largest delta.
  generate
    if (TIME_BITS >= IN_TIME_BITS) begin : g_wide
      assign t_sat = TIME_BITS'(s_axis_tdata[39:8]);
    end else begin : g_narrow
      assign t_sat = (|s_axis_tdata[39:8+TIME_BITS]) ? {TIME_BITS{1'b1}}
                                                     : s_axis_tdata[8+TIME_BITS-1:8];
    end
  endgenerate

  // Delta of the cell the insert token currently sits on.
  always_comb begin
    sel_delta = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pos == IW'(i)) begin
        sel_delta = delta_q[i];
      end
    end
  end

  // The new entry goes ahead of the first entry whose total wake time is at
  // least the requested one, which is the case once the remaining delay is no
  // larger than that entry's delta.
  assign at_end    = (pos == occ);
  assign hit       = (rem <= sel_delta);
  assign head_zero = (occ != '0) && (delta_q[0] == '0);
  assign next_zero = (occ > IW'(1)) && (delta_q[NEXT_IDX] == '0);

  always_comb begin
    state_next  = state;
    ctrl.op     = OP_HOLD;
    ctrl.new_id = new_id;
    emit        = 1'b0;
    emit_kind   = KIND_STATUS;
    emit_id     = '0;
    emit_status = ST_ACCEPTED;
    emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (s_axis_tuser == CMD_TICK) ? S_TICK : S_ADD;
        end
      end
      S_ADD: begin
        if (rem == '0) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_status = ST_IGNORED;
            state_next  = S_IDLE;
          end
        end else if (occ == DEPTH_IDX) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
            state_next  = S_IDLE;
          end
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (at_end || hit) begin
          if (can_emit) begin
            ctrl.op     = OP_INSERT;
            emit        = 1'b1;
            emit_status = ST_ACCEPTED;
            state_next  = S_IDLE;
          end
        end
      end
      S_TICK: begin
        ctrl.op    = OP_DEC;
        state_next = S_REL;
      end
      S_REL: begin
        if (!head_zero) begin
          state_next = S_IDLE;
        end else if (can_emit) begin
          ctrl.op   = OP_POP;
          emit      = 1'b1;
          emit_kind = KIND_WOKEN;
          emit_id   = id_q[0];
          emit_last = !next_zero;
          if (!next_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.op == OP_INSERT) begin
        occ <= occ + IW'(1);
      end else if (ctrl.op == OP_POP) begin
        occ <= occ - IW'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, the walking insert token and the output result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      new_id <= s_axis_tdata[7:0];
      rem    <= t_sat;
      pos    <= '0;
    end else if (state == S_WALK && !(at_end || hit)) begin
      rem <= rem - sel_delta;
      pos <= pos + IW'(1);
    end
    if (emit) begin
      out_kind   <= emit_kind;
      out_id     <= emit_id;
      out_status <= emit_status;
      out_last   <= emit_last;
    end
  end

  generate
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      localparam int L = (k > 0) ? k - 1 : k;
      localparam int R = (k < QUEUE_DEPTH - 1) ? k + 1 : k;
      sdq_cell #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .INDEX       (k)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .pos         (pos),
        .rem         (rem),
        .left_delta  (delta_q[L]),
        .left_id     (id_q[L]),
        .right_delta (delta_q[R]),
        .right_id    (id_q[R]),
        .delta       (delta_q[k]),
        .id          (id_q[k])
      );
    end
  endgenerate

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_status, out_id};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= DEPTH_IDX)
    else $error("queue occupancy beyond depth");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (pos <= occ) && (occ < DEPTH_IDX))
    else $error("insert token outside the live entries or queue full");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_INSERT) |=> (occ == $past(occ) + IW'(1)))
    else $error("insert did not grow the queue by one");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_POP) |-> (occ != '0) && (delta_q[0] == '0) && emit)
    else $error("release of a head entry that is not due");

  a_release_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_REL && emit && emit_last) |=> (state == S_IDLE))
    else $error("release run continued after its last report");
`endif

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench;
  import sdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off in the pressure test
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int TAIL_CYCLES    = DEPTH + 8;
  localparam int RANDOM_ITEMS   = 290;

  // One result as the block should report it.
  typedef struct packed {
    logic                   kind;
    logic [ID_BITS-1:0]     id;
    logic [STATUS_BITS-1:0] status;
    logic                   last;
  } sleep_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_valid = 1'b0;
  logic [39:0] s_data  = '0;
  logic        s_user  = 1'b0;
  logic        m_ready = 1'b0;

  wire logic        s_axis_tready;
  wire logic        m_axis_tvalid;
  wire logic [15:0] m_axis_tdata;
  wire logic        m_axis_tuser;
  wire logic        m_axis_tlast;

  sleep_delta_queue_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The clock starts low, so the first rising edge falls at 10 ns.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own picture of the queue: relative delays and ids in wake order.
  logic [IN_TIME_BITS-1:0] wake_delta [DEPTH];
  logic [ID_BITS-1:0]      wake_id    [DEPTH];
  int                      sleeper_count = 0;

  // Reports still owed by the block, oldest first.
  sleep_report_t expected_reports[$];

  // Statistics for the closing summary.
  int adds_seen    = 0;
  int adds_ignored = 0;
  int adds_refused = 0;
  int ticks_seen   = 0;
  int wakes_seen   = 0;
  int widest_burst = 0;

  int mismatch_count = 0;
  int stray_count    = 0;

  // Sender burst control and receiver hold-off handshake.
  int burst_left    = 0;
  bit gaps_on       = 1'b1;
  int hold_requests = 0;

  // Work out what one accepted request does to the queue, and queue up the reports
  // it must cause. A tick releases every leading entry whose delay reaches zero; an
  // add slots in ahead of the first entry that wakes at the same time or later.
  task automatic advance_sleep_queue(input logic cmd, input logic [ID_BITS-1:0] tid,
                                     input logic [IN_TIME_BITS-1:0] ticks);
    int            pos;
    int            j;
    int            released;
    bit            found;
    logic [63:0]   cum;
    logic [63:0]   own_delta;
    sleep_report_t rep;
    released = 0;
    found    = 1'b0;
    cum      = '0;
    if (cmd == CMD_TICK) begin
      if (sleeper_count == 0) return;
      ticks_seen++;
      if (wake_delta[0] != 0) wake_delta[0] = wake_delta[0] - 1;
      while (sleeper_count > 0 && wake_delta[0] == 0) begin
        rep.kind   = KIND_WOKEN;
        rep.id     = wake_id[0];
        rep.status = ST_ACCEPTED;
        for (j = 1; j < sleeper_count; j++) begin
          wake_delta[j-1] = wake_delta[j];
          wake_id[j-1]    = wake_id[j];
        end
        sleeper_count--;
        // The burst ends unless the new head is also due now.
        rep.last = !(sleeper_count > 0 && wake_delta[0] == 0);
        expected_reports.push_back(rep);
        released++;
      end
      wakes_seen += released;
      if (released > widest_burst) widest_burst = released;
    end else begin
      adds_seen++;
      rep.kind = KIND_STATUS;
      rep.id   = '0;
      rep.last = 1'b1;
      if (ticks == 0) begin
        rep.status = ST_IGNORED;
        adds_ignored++;
      end else if (sleeper_count >= DEPTH) begin
        rep.status = ST_FULL;
        adds_refused++;
      end else begin
        rep.status = ST_ACCEPTED;
        pos = 0;
        while (pos < sleeper_count && !found) begin
          cum = cum + wake_delta[pos];
          if (cum >= ticks) found = 1'b1;
          else pos++;
        end
        if (found) begin
          cum       = cum - wake_delta[pos];
          own_delta = ticks - cum;
          // The entry we go ahead of now counts from our wake time instead.
          wake_delta[pos] = wake_delta[pos] - own_delta[IN_TIME_BITS-1:0];
          for (j = sleeper_count; j > pos; j--) begin
            wake_delta[j] = wake_delta[j-1];
            wake_id[j]    = wake_id[j-1];
          end
        end else begin
          own_delta = ticks - cum;
        end
        wake_delta[pos] = own_delta[IN_TIME_BITS-1:0];
        wake_id[pos]    = tid;
        sleeper_count++;
      end
      expected_reports.push_back(rep);
    end
  endtask

  // Offer one request and wait for the block to take it. Requests go out in bursts;
  // between bursts, while gaps are on, the valid line drops for a random gap.
  task automatic send_request(input logic cmd, input logic [ID_BITS-1:0] tid,
                              input logic [IN_TIME_BITS-1:0] ticks);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        s_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_valid <= 1'b1;
    s_data  <= {ticks, tid};
    s_user  <= cmd;
    do @(posedge clk); while (!(s_valid && s_axis_tready));
    advance_sleep_queue(cmd, tid, ticks);
  endtask

  // Tick until every sleeper has been woken.
  task automatic drain_sleepers();
    while (sleeper_count > 0) send_request(CMD_TICK, '0, '0);
  endtask

  // Ticks on an empty queue do nothing; a zero sleep time is refused as ignored.
  task automatic test_empty_queue();
    send_request(CMD_TICK, 8'h00, '0);
    send_request(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 8'hFF, '0);
    send_request(CMD_TICK, 8'h00, '0);
  endtask

  // Entries with the same wake time leave on the same tick, newest first, and an
  // insert in the middle of the list shortens the delay of the entry behind it.
  task automatic test_equal_wake_times();
    send_request(CMD_ADD, 8'h01, 32'd3);
    send_request(CMD_ADD, 8'h02, 32'd3);
    send_request(CMD_ADD, 8'h03, 32'd3);
    send_request(CMD_ADD, 8'h04, 32'd1);
    send_request(CMD_ADD, 8'h05, 32'd2);
    send_request(CMD_ADD, 8'h06, 32'd5);
    drain_sleepers();
  endtask

  // Fill every slot with the same wake time, then try to add one more: a nonzero
  // time is refused as full, a zero time is still reported as ignored. The second
  // tick then wakes the whole queue in one burst.
  task automatic test_full_queue();
    int i;
    for (i = 0; i < DEPTH; i++) send_request(CMD_ADD, 8'h10 + i[7:0], 32'd2);
    send_request(CMD_ADD, 8'hEE, 32'd1);
    send_request(CMD_ADD, 8'hDD, '0);
    drain_sleepers();
  endtask

  // Mostly short sleeps so that threads keep waking, with clusters of equal wake
  // times, some longer sleeps that land deep in the list, zero times as noise and
  // the odd tick on an empty queue. Ticks grow likelier as the queue fills up.
  task automatic test_random_traffic(input int items);
    int   done;
    int   pick;
    int   tick_pct;
    logic [IN_TIME_BITS-1:0] ticks;
    done = 0;
    while (done < items) begin
      gaps_on  = ((done / 60) % 3) != 2;
      tick_pct = (sleeper_count == 0) ? 5 : 25 + 4 * sleeper_count;
      if ($urandom_range(0, 99) < tick_pct) begin
        if (sleeper_count > 0) done++;
        send_request(CMD_TICK, 8'($urandom_range(0, 255)), $urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      ticks = $urandom_range(1, 12);
        else if (pick < 82) ticks = $urandom_range(1, 3);
        else if (pick < 94) ticks = $urandom_range(13, 40);
        else                ticks = '0;
        done++;
        send_request(CMD_ADD, 8'($urandom_range(0, 255)), ticks);
      end
    end
    gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the
  // block backs up and has to stall its request side.
  task automatic test_backpressure();
    int i;
    gaps_on = 1'b0;
    hold_requests++;
    for (i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_request(CMD_TICK, '0, '0);
      else send_request(CMD_ADD, 8'($urandom_range(0, 255)), $urandom_range(1, 4));
    end
    gaps_on = 1'b1;
    drain_sleepers();
  endtask

  // Sleep times at the top of the range. These sleepers never wake within the run,
  // so this comes last; a short sleeper still gets out ahead of them.
  task automatic test_wide_times();
    send_request(CMD_ADD, 8'hFF, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 8'h00, 32'h8000_0000);
    send_request(CMD_ADD, 8'h5A, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 8'hA5, 32'h7FFF_FFFF);
    send_request(CMD_ADD, 8'($urandom_range(0, 255)), $urandom);
    send_request(CMD_ADD, 8'h3C, 32'd1);
    send_request(CMD_TICK, '0, '0);
    send_request(CMD_TICK, '0, '0);
  endtask

  // Receiver: a stall pattern that cycles through always ready, light stalls and
  // heavy stalls, plus the long hold-off that the pressure test asks for.
  int rx_cycle    = 0;
  int holds_taken = 0;
  int hold_left   = 0;
  int stall_left  = 0;

  always @(negedge clk) begin
    int stall_pct;
    rx_cycle++;
    case ((rx_cycle / 256) % 3)
      0:       stall_pct = 0;
      1:       stall_pct = 25;
      default: stall_pct = 60;
    endcase
    if (holds_taken != hold_requests) begin
      holds_taken = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 5);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Checker: every report taken from the block must match the oldest one owed.
  always @(posedge clk) begin
    sleep_report_t want;
    if (!rst && m_axis_tvalid && m_ready) begin
      if (expected_reports.size() == 0) begin
        stray_count++;
        if (stray_count + mismatch_count <= 10)
          $display("%0t: unexpected report kind=%0d id=%02h status=%0d last=%0d",
                   $realtime, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                   m_axis_tlast);
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.id ||
            m_axis_tdata[9:8] !== want.status || m_axis_tdata[15:10] !== 6'd0 ||
            m_axis_tlast !== want.last) begin
          mismatch_count++;
          if (stray_count + mismatch_count <= 10)
            $display("%0t: report mismatch: expected kind=%0d id=%02h status=%0d last=%0d,%s",
                     $realtime, want.kind, want.id, want.status, want.last,
                     $sformatf(" got kind=%0d id=%02h status=%0d pad=%02h last=%0d",
                               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                               m_axis_tdata[15:10], m_axis_tlast));
        end
      end
    end
  end

  // Watchdog: too long without a handshake on either side means the block has hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles with no request or report moving.",
               WATCHDOG_LIMIT);
      $display("sleep_delta_queue_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence. Reset is held at the start and released on a falling edge.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_equal_wake_times();
    test_full_queue();
    test_random_traffic(RANDOM_ITEMS);
    test_backpressure();
    test_wide_times();

    @(negedge clk);
    s_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d adds (%0d ignored, %0d refused as full) and %0d live ticks.",
             adds_seen, adds_ignored, adds_refused, ticks_seen);
    $display("%0d threads woke, at most %0d on one tick; %0d mismatches, %0d stray reports.",
             wakes_seen, widest_burst, mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && expected_reports.size() == 0) begin
      $display("sleep_delta_queue_top test passed");
    end else begin
      $display("sleep_delta_queue_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
